// ----- rtl/i8mmzp_pkg.sv -----
// i8mmzp_pkg: types and constants for the int8 matrix multiply with zero points
// no dependencies; imported by int8_matmul_zero_point
package i8mmzp_pkg;

    localparam int MAX_ROWS  = 16;
    localparam int MAX_INNER = 16;
    localparam int MAX_COLS  = 16;

    localparam int A_DEPTH = MAX_ROWS * MAX_INNER;
    localparam int B_DEPTH = MAX_INNER * MAX_COLS;
    localparam int A_AW    = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
    localparam int B_AW    = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

    localparam int DIM_W   = 5;
    localparam int CFG_IW  = 3;
    localparam int CFG_DW  = 32;
    localparam int PROD_W  = 18;

    typedef enum logic [CFG_IW-1:0] {
        CFG_ROWS_USED   = 3'd0,
        CFG_INNER_USED  = 3'd1,
        CFG_COLS_USED   = 3'd2,
        CFG_A_ZERO      = 3'd3,
        CFG_B_ZERO      = 3'd4,
        CFG_RESULT_BIAS = 3'd5
    } cfg_index_t;

    typedef enum logic [1:0] {
        KIND_WRITE_A = 2'd0,
        KIND_WRITE_B = 2'd1,
        KIND_COMPUTE = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [3:0]        row_index;
        logic [3:0]        col_index;
        logic signed [7:0] elem_value;
    } in_item_t;

    typedef struct packed {
        logic [3:0]         out_row;
        logic [3:0]         out_col;
        logic signed [31:0] dot_value;
        logic               index_error;
    } out_item_t;

endpackage

// ----- rtl/int8_matmul_zero_point.sv -----
// int8_matmul_zero_point: element store and dot-product engine for C = (A+za)(B+zb) + bias
// depends on i8mmzp_pkg (types, dimension constants)
//
//  port group   dir  handshake              payload
//  in_*         in   in_valid / in_ready    in_item_t  (write A, write B, compute request)
//  out_*        out  out_valid / out_ready  out_item_t (one per compute request)
//  cfg_*        in   cfg_write, no wait     cfg_index, cfg_data
//
//  an element write is written into the store at acceptance
//  a compute request does one store read per k through
//  the single read port of each memory, then the multiplier and accumulator stages drain
//  an out of range request or a zero inner dimension skips the walk
//  rst_n resets control and configuration; the stores hold no reset value
//  the result sits in an output register, so a waiting result does not hold off
//  the next transaction unless a second result is ready before the first is taken
module int8_matmul_zero_point
    import i8mmzp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item,
    input  logic                 cfg_write,
    input  logic [CFG_IW-1:0]    cfg_index,
    input  logic [CFG_DW-1:0]    cfg_data
);

    // configuration registers
    logic [DIM_W-1:0]   rows_reg;
    logic [DIM_W-1:0]   inner_reg;
    logic [DIM_W-1:0]   cols_reg;
    logic signed [7:0]  a_zero_reg;
    logic signed [7:0]  b_zero_reg;
    logic [31:0]        bias_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg   <= DIM_W'(16);
            inner_reg  <= DIM_W'(16);
            cols_reg   <= DIM_W'(16);
            a_zero_reg <= '0;
            b_zero_reg <= '0;
            bias_reg   <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_ROWS_USED:   rows_reg   <= cfg_data[DIM_W-1:0];
                CFG_INNER_USED:  inner_reg  <= cfg_data[DIM_W-1:0];
                CFG_COLS_USED:   cols_reg   <= cfg_data[DIM_W-1:0];
                CFG_A_ZERO:      a_zero_reg <= cfg_data[7:0];
                CFG_B_ZERO:      b_zero_reg <= cfg_data[7:0];
                CFG_RESULT_BIAS: bias_reg   <= cfg_data;
                default:         ;
            endcase
        end
    end

    // dimensions saturate at the store size
    logic [DIM_W-1:0] m_dim;
    logic [DIM_W-1:0] n_dim;
    logic [DIM_W-1:0] p_dim;

    assign m_dim = (rows_reg  > DIM_W'(MAX_ROWS))  ? DIM_W'(MAX_ROWS)  : rows_reg;
    assign n_dim = (inner_reg > DIM_W'(MAX_INNER)) ? DIM_W'(MAX_INNER) : inner_reg;
    assign p_dim = (cols_reg  > DIM_W'(MAX_COLS))  ? DIM_W'(MAX_COLS)  : cols_reg;

    // control state
    state_t            state_reg, state_next;
    logic [3:0]        row_reg, row_next;
    logic [3:0]        col_reg, col_next;
    logic              err_reg, err_next;
    logic [DIM_W-1:0]  n_reg, n_next;
    logic [DIM_W-1:0]  k_reg, k_next;
    logic              out_valid_reg, out_valid_next;
    out_item_t         out_item_reg, out_item_next;

    // read and multiply pipeline
    logic              rd_en;
    logic              rd_vld_reg;
    logic              mul_vld_reg;
    logic signed [7:0] a_q_reg;
    logic signed [7:0] b_q_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [31:0]       acc_reg;
    logic              acc_clear;

    logic              in_fire;
    logic              req_err;
    logic              out_free;
    logic [A_AW-1:0]   a_wr_addr, a_rd_addr;
    logic [B_AW-1:0]   b_wr_addr, b_rd_addr;
    logic              a_wr_en, b_wr_en;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign req_err  = ({1'b0, in_item.row_index} >= m_dim) ||
                      ({1'b0, in_item.col_index} >= p_dim);

    // write addressing, writes outside the store are dropped
    assign a_wr_addr = A_AW'(in_item.row_index) * A_AW'(MAX_INNER) + A_AW'(in_item.col_index);
    assign b_wr_addr = B_AW'(in_item.row_index) * B_AW'(MAX_COLS) + B_AW'(in_item.col_index);
    assign a_wr_en   = in_fire && (in_item.kind == KIND_WRITE_A) &&
                       (int'(in_item.row_index) < MAX_ROWS) &&
                       (int'(in_item.col_index) < MAX_INNER);
    assign b_wr_en   = in_fire && (in_item.kind == KIND_WRITE_B) &&
                       (int'(in_item.row_index) < MAX_INNER) &&
                       (int'(in_item.col_index) < MAX_COLS);

    // read walks row of A and column of B
    assign a_rd_addr = A_AW'(row_reg) * A_AW'(MAX_INNER) + A_AW'(k_reg);
    assign b_rd_addr = B_AW'(k_reg) * B_AW'(MAX_COLS) + B_AW'(col_reg);

    // element stores, one write and one read port each, registered read data
    logic [7:0] a_mem [A_DEPTH];
    logic [7:0] b_mem [B_DEPTH];

    always_ff @(posedge clk)
    begin
        if (a_wr_en)
        begin
            a_mem[a_wr_addr] <= in_item.elem_value;
        end
        if (rd_en)
        begin
            a_q_reg <= a_mem[a_rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_wr_en)
        begin
            b_mem[b_wr_addr] <= in_item.elem_value;
        end
        if (rd_en)
        begin
            b_q_reg <= b_mem[b_rd_addr];
        end
    end

    // offset operands, 9 bit signed each
    logic signed [8:0] a_off;
    logic signed [8:0] b_off;

    assign a_off = 9'(a_q_reg) + 9'(a_zero_reg);
    assign b_off = 9'(b_q_reg) + 9'(b_zero_reg);

    always_ff @(posedge clk)
    begin
        if (rd_vld_reg)
        begin
            prod_reg <= a_off * b_off;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_vld_reg  <= 1'b0;
            mul_vld_reg <= 1'b0;
            acc_reg     <= '0;
        end
        else
        begin
            rd_vld_reg  <= rd_en;
            mul_vld_reg <= rd_vld_reg;
            if (acc_clear)
            begin
                acc_reg <= '0;
            end
            else if (mul_vld_reg)
            begin
                acc_reg <= acc_reg + {{(32-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            end
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            err_reg       <= 1'b0;
            n_reg         <= '0;
            k_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            err_reg       <= err_next;
            n_reg         <= n_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        err_next       = err_reg;
        n_next         = n_reg;
        k_next         = k_reg;
        out_item_next  = out_item_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        rd_en          = 1'b0;
        acc_clear      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && (in_item.kind == KIND_COMPUTE))
                begin
                    row_next  = in_item.row_index;
                    col_next  = in_item.col_index;
                    err_next  = req_err;
                    n_next    = n_dim;
                    k_next    = '0;
                    acc_clear = 1'b1;
                    // empty sum or bad index skips the walk
                    state_next = (req_err || (n_dim == '0)) ? ST_DONE : ST_RUN;
                end
            end
            ST_RUN:
            begin
                rd_en  = 1'b1;
                k_next = k_reg + DIM_W'(1);
                if (k_next == n_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!rd_vld_reg && !mul_vld_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_item_next.out_row     = row_reg;
                    out_item_next.out_col     = col_reg;
                    out_item_next.index_error = err_reg;
                    out_item_next.dot_value   = err_reg ? '0 : acc_reg + bias_reg;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    // pipeline is empty whenever a new transaction can enter
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> (!rd_vld_reg && !mul_vld_reg))
        else $error("read pipeline busy while idle");

    // the walk never passes the inner dimension
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN) |-> (k_reg < n_reg))
        else $error("inner index beyond dimension");

    // a flagged request always carries a zero value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.index_error) |-> (out_item.dot_value == '0))
        else $error("index error with non-zero value");

    // a result is only loaded when the output register is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid && !out_ready) |=> (state_reg == ST_DONE))
        else $error("result overwrote a pending transaction");

endmodule
